// ===== hdl/sigma_clipped_mean_filter_macros.svh =====
// Assertion helpers for the filter
`ifndef SIGMA_CLIPPED_MEAN_FILTER_MACROS_SVH
`define SIGMA_CLIPPED_MEAN_FILTER_MACROS_SVH

// Check that an implication holds at every edge outside reset
`define SCMF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition holds in the cycle after another holds
`define SCMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/scmf_pkg.sv =====
package scmf_pkg;
  localparam int MAX_BATCH_DEF = 16;
  localparam logic [4:0] BATCH_SIZE_RST = 5'd10;
  localparam int Q4_SHIFT = 4;
  localparam int SAMPLE_W = 15;

  // Batch handed from the front part to the back part
  typedef struct packed {
    logic [6:0]  n;
    logic [21:0] s;
    logic [37:0] q;
    logic        bank;
  } batch_t;
endpackage

// ===== hdl/scmf_ram.sv =====
module scmf_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/scmf_front.sv =====
module scmf_front #(
  parameter int MAX_BATCH = scmf_pkg::MAX_BATCH_DEF,
  parameter int AW = $clog2(MAX_BATCH) + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [15:0]    range_sample,
  input  logic                  single_target,
  input  logic [4:0]            batch_size,
  input  logic                  bank_free,
  output logic                  st_we,
  output logic [AW-1:0]         st_waddr,
  output logic [scmf_pkg::SAMPLE_W-1:0] st_wdata,
  output logic                  b_valid,
  output scmf_pkg::batch_t      b_data
);
  localparam int NW = $clog2(MAX_BATCH + 1);
  logic [NW-1:0] counted, positives;
  logic [21:0] psum;
  logic [37:0] qsum;
  logic bank;
  logic [NW-1:0] eff, counted_next;
  logic [31:0] sq;
  logic sq_v;
  logic is_pos, take, done;
  logic [NW-1:0] positives_next;
  logic [21:0] psum_next;
  logic [NW-1:0] positives_last;
  logic [21:0] psum_last;

  always_comb begin
    if (batch_size == 5'd0) begin
      eff = NW'(1);
    end else if (32'(batch_size) > MAX_BATCH) begin
      eff = NW'(MAX_BATCH);
    end else begin
      eff = NW'(batch_size);
    end
  end

  // Full while a square is added or a batch end finds the back part busy
  assign full = sq_v || (!bank_free && (counted_next >= eff));
  assign take = push && !full && single_target;
  assign is_pos = !range_sample[15] && (range_sample != 16'sd0)
                  && (32'(positives) < MAX_BATCH);
  assign counted_next = counted + NW'(1);
  assign done = take && (counted_next >= eff);
  assign positives_next = positives + NW'(take && is_pos);
  assign psum_next = psum + ((take && is_pos) ? 22'(range_sample[14:0]) : 22'd0);

  assign st_we = take && is_pos;
  assign st_waddr = {bank, positives[AW-2:0]};
  assign st_wdata = range_sample[14:0];

  // Squares are registered and added in the cycle after the sample is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      counted <= '0;
      positives <= '0;
      psum <= '0;
      qsum <= '0;
      bank <= 1'b0;
      sq_v <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      b_valid <= 1'b0;
      sq_v <= 1'b0;
      if (take) begin
        sq_v <= 1'b1;
        positives <= done ? '0 : positives_next;
        psum <= done ? '0 : psum_next;
        counted <= done ? '0 : counted_next;
      end
      if (sq_v) begin
        if (counted == '0) begin
          b_valid <= 1'b1;
          b_data.n <= 7'(positives_last);
          b_data.s <= psum_last;
          b_data.q <= qsum + 38'(sq);
          b_data.bank <= bank;
          bank <= !bank;
          qsum <= '0;
        end else begin
          qsum <= qsum + 38'(sq);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      positives_last <= positives_next;
      psum_last <= psum_next;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      sq <= '0;
    end else if (take) begin
      sq <= 32'(is_pos ? range_sample[14:0] : 15'd0) * 32'(is_pos ? range_sample[14:0] : 15'd0);
    end
  end
endmodule

// ===== hdl/scmf_back.sv =====
module scmf_back #(
  parameter int MAX_BATCH = scmf_pkg::MAX_BATCH_DEF,
  parameter int AW = $clog2(MAX_BATCH) + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  b_valid,
  input  scmf_pkg::batch_t      b_data,
  output logic                  busy,
  output logic [AW-1:0]         st_raddr,
  input  logic [scmf_pkg::SAMPLE_W-1:0] st_rdata,
  output logic                  r_valid,
  input  logic                  r_ready,
  output logic [18:0]           r_mean,
  output logic                  r_mv,
  output logic [4:0]            r_kept,
  output logic [4:0]            r_pos
);
  localparam logic [2:0] S_IDLE = 3'd0, S_LIM = 3'd1, S_SCAN = 3'd2,
                         S_DIV = 3'd3, S_OUT = 3'd4;
  logic [2:0] state;
  scmf_pkg::batch_t b;
  logic signed [47:0] limit;
  logic [6:0] idx;
  logic idx_v;
  logic signed [23:0] d;
  logic signed [47:0] dd;
  logic dd_v, d_v;
  logic [6:0] kept;
  logic [21:0] ksum;
  logic [25:0] rem, quo;
  logic [4:0] dstep;
  logic [26:0] trial;
  logic [scmf_pkg::SAMPLE_W-1:0] dx, ddx;

  assign busy = state != S_IDLE;
  assign st_raddr = {b.bank, idx[AW-2:0]};
  assign trial = {rem[25:0], 1'b0} | 27'(quo[25]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r_valid <= 1'b0;
      idx_v <= 1'b0;
      d_v <= 1'b0;
      dd_v <= 1'b0;
    end else begin
      if (state == S_OUT && (!r_valid || r_ready)) begin
        r_valid <= 1'b1;
      end else if (r_valid && r_ready) begin
        r_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (b_valid) begin
            b <= b_data;
            state <= S_LIM;
          end
        end
        S_LIM: begin
          limit <= 48'($signed({1'b0, b.n})) * 48'($signed({1'b0, b.q}))
                   - 48'($signed({1'b0, b.s})) * 48'($signed({1'b0, b.s}));
          idx <= '0;
          kept <= '0;
          ksum <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          idx_v <= idx < b.n;
          if (idx < b.n) begin
            idx <= idx + 7'd1;
          end
          d_v <= idx_v;
          if (idx_v) begin
            d <= $signed(24'(st_rdata) * 24'(b.n)) - $signed({2'b0, b.s});
            dx <= st_rdata;
          end
          dd_v <= d_v;
          if (d_v) begin
            dd <= 48'(d) * 48'(d);
            ddx <= dx;
          end
          if (dd_v && dd <= limit) begin
            kept <= kept + 7'd1;
            ksum <= ksum + 22'(ddx);
          end
          if (!(idx < b.n) && !idx_v && !d_v && !dd_v) begin
            quo <= {ksum, 4'b0};
            rem <= '0;
            dstep <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle
          if (kept == 7'd0) begin
            quo <= '0;
            state <= S_OUT;
          end else begin
            if (trial >= 27'(kept)) begin
              rem <= 26'(trial - 27'(kept));
              quo <= {quo[24:0], 1'b1};
            end else begin
              rem <= 26'(trial);
              quo <= {quo[24:0], 1'b0};
            end
            dstep <= dstep + 5'd1;
            if (dstep == 5'd25) begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!r_valid || r_ready) begin
            r_mean <= 19'(quo);
            r_mv <= kept != 7'd0;
            r_kept <= 5'(kept);
            r_pos <= 5'(b.n);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/sigma_clipped_mean_filter.sv =====
// channel   | handshake      | payload
// input     | push / full    | range_sample, single_target
// result    | empty / pop    | filtered_mean_q4, mean_valid, kept_count, positive_count
// config    | cfg_we         | cfg_data (batch_size)
// A counted sample is taken while full is low; the next waits while the square
// of the last one is added. A batch end hands the sums to the back part, which computes
// the limit, scans the sample RAM and runs the 26-step divider. The front part fills
// the other RAM bank meanwhile and, besides the square wait, stalls only if a second
// batch ends before the back part is free. Reset is synchronous; one result register.
`include "sigma_clipped_mean_filter_macros.svh"
module sigma_clipped_mean_filter #(
  parameter int MAX_BATCH = scmf_pkg::MAX_BATCH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] range_sample,
  input  logic               single_target,
  output logic               empty,
  input  logic               pop,
  output logic [18:0]        filtered_mean_q4,
  output logic               mean_valid,
  output logic [4:0]         kept_count,
  output logic [4:0]         positive_count,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data
);
  localparam int AW = $clog2(MAX_BATCH) + 1;
  logic [4:0] batch_size;
  logic busy, b_valid, st_we, r_valid;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [scmf_pkg::SAMPLE_W-1:0] st_wdata, st_rdata;
  scmf_pkg::batch_t b_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size <= scmf_pkg::BATCH_SIZE_RST;
    end else if (cfg_we) begin
      batch_size <= cfg_data;
    end
  end

  scmf_front #(.MAX_BATCH(MAX_BATCH), .AW(AW)) u_front (
    .clk, .rst, .push, .full, .range_sample, .single_target, .batch_size,
    .bank_free(!busy && !b_valid), .st_we, .st_waddr, .st_wdata, .b_valid, .b_data
  );

  scmf_ram #(.WIDTH(scmf_pkg::SAMPLE_W), .DEPTH(2 ** AW)) u_ram (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(st_raddr),
    .rdata(st_rdata)
  );

  scmf_back #(.MAX_BATCH(MAX_BATCH), .AW(AW)) u_back (
    .clk, .rst, .b_valid, .b_data, .busy, .st_raddr, .st_rdata,
    .r_valid, .r_ready(pop), .r_mean(filtered_mean_q4), .r_mv(mean_valid),
    .r_kept(kept_count), .r_pos(positive_count)
  );

  assign empty = !r_valid;

  `SCMF_ASSERT_IMP(a_kept_le_pos, !empty, kept_count <= positive_count, "kept above positives")
  `SCMF_ASSERT_IMP(a_mean_zero, !empty && !mean_valid, filtered_mean_q4 == 19'd0, "mean not zero")
  `SCMF_ASSERT_NEXT(a_hold, !empty && !pop, !empty, "result dropped")
endmodule
